// File: hdl/rbm_pkg.sv
// Shared widths, codes and helpers for the relative body motion pipeline.
package rbm_pkg;

    localparam int POS_WIDTH_DEF = 32;
    localparam int QW            = 16;   // quaternion lane, Q1.14
    localparam int VW            = 21;   // velocity and rate lane
    localparam int MW            = 34;   // rotation matrix entry
    localparam int M_FRAC        = 28;

    localparam int POS_SH   = 28;
    localparam int CROSS_SH = 13;
    localparam int U1_SH    = 23;
    localparam int B_SH     = 28;
    localparam int VEL_SH   = 38;
    localparam int E_SH     = 15;
    localparam int RATE_SH  = 41;
    localparam int QUAT_SH  = 14;

    // row-major 3x3, entry [3*row + col]
    typedef logic [8:0][MW-1:0] mat_t;

    // quaternion product q2 * conj(q1): term t of lane k is +/- q2[QA] * c[QB]
    localparam int QA [4][4] = '{'{0, 1, 2, 3}, '{0, 1, 2, 3}, '{0, 2, 3, 1}, '{0, 3, 1, 2}};
    localparam int QB [4][4] = '{'{0, 1, 2, 3}, '{1, 0, 3, 2}, '{2, 0, 1, 3}, '{3, 0, 2, 1}};
    localparam bit QN [4][4] = '{'{0, 1, 1, 1}, '{0, 0, 0, 1}, '{0, 0, 0, 1}, '{0, 0, 0, 1}};

    // lane k of a packed triple, first lane in the top bits
    function automatic logic signed [VW-1:0] lane3(input logic [3*VW-1:0] v, input int k);
        return v[(2-k)*VW +: VW];
    endfunction

endpackage

// File: hdl/rbm_mul.sv
// Two-stage signed multiplier, second operand split into two partial products.
module rbm_mul
    import rbm_pkg::*;
#(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int LO = (BW + 1) / 2;
    localparam int HI = BW - LO;

    logic signed [AW+LO:0]     lo_reg;
    logic signed [AW+HI-1:0]   hi_reg;
    logic signed [AW+BW-1:0]   p_reg;
    logic signed [AW+BW-1:0]   p_next;

    assign p_next = ((AW+BW)'(hi_reg) <<< LO) + (AW+BW)'(lo_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= a * $signed({1'b0, b[LO-1:0]});
            hi_reg <= a * $signed(b[BW-1:LO]);
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: hdl/rbm_sum.sv
// Registered adder of N terms with round half up and signed saturation.
module rbm_sum
    import rbm_pkg::*;
#(
    parameter int N  = 3,
    parameter int IW = 64,
    parameter int SH = 28,
    parameter int OW = 32
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [IW-1:0] terms [N],
    output logic signed [OW-1:0] res,
    output logic                 clip
);

    localparam int SW = IW + $clog2(N) + 1;

    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] shr;
    logic signed [SW-1:0] hi_lim;
    logic signed [SW-1:0] lo_lim;
    logic signed [OW-1:0] res_next;
    logic signed [OW-1:0] res_reg;
    logic                 clip_next;
    logic                 clip_reg;

    always_comb
    begin
        acc = SW'(1) <<< (SH - 1);
        for (int k = 0; k < N; k++)
        begin
            acc = acc + SW'(terms[k]);
        end
        shr    = acc >>> SH;
        hi_lim = (SW'(1) <<< (OW - 1)) - SW'(1);
        lo_lim = ~hi_lim;
        if (shr > hi_lim)
        begin
            res_next  = OW'(hi_lim);
            clip_next = 1'b1;
        end
        else if (shr < lo_lim)
        begin
            res_next  = OW'(lo_lim);
            clip_next = 1'b1;
        end
        else
        begin
            res_next  = OW'(shr);
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg  <= res_next;
            clip_reg <= clip_next;
        end
    end

    assign res  = res_reg;
    assign clip = clip_reg;

endmodule

// File: hdl/rbm_delay.sv
// Enabled shift line that carries a payload a fixed number of stages.
module rbm_delay
    import rbm_pkg::*;
#(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [N-1:0][W-1:0] line_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int k = 1; k < N; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign q = line_reg[N-1];

endmodule

// File: hdl/rbm_quat.sv
// Quaternion to rotation matrix, two stages: doubled products, then sums.
module rbm_quat
    import rbm_pkg::*;
(
    input  logic            clk,
    input  logic            en,
    input  logic [4*QW-1:0] q,
    output mat_t            m
);

    localparam int SW = 2*QW + 1;

    logic signed [QW-1:0] w, x, y, z;
    logic signed [SW-1:0] xx_reg, yy_reg, zz_reg, xy_reg, wz_reg;
    logic signed [SW-1:0] zx_reg, wy_reg, yz_reg, wx_reg;
    logic signed [MW-1:0] one;
    mat_t                 m_next;
    mat_t                 m_reg;

    assign w   = q[3*QW +: QW];
    assign x   = q[2*QW +: QW];
    assign y   = q[QW +: QW];
    assign z   = q[0 +: QW];
    assign one = MW'(1) <<< M_FRAC;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= (SW'(x) * SW'(x)) <<< 1;
            yy_reg <= (SW'(y) * SW'(y)) <<< 1;
            zz_reg <= (SW'(z) * SW'(z)) <<< 1;
            xy_reg <= (SW'(x) * SW'(y)) <<< 1;
            wz_reg <= (SW'(w) * SW'(z)) <<< 1;
            zx_reg <= (SW'(z) * SW'(x)) <<< 1;
            wy_reg <= (SW'(w) * SW'(y)) <<< 1;
            yz_reg <= (SW'(y) * SW'(z)) <<< 1;
            wx_reg <= (SW'(w) * SW'(x)) <<< 1;
        end
    end

    always_comb
    begin
        m_next[0] = one - MW'(yy_reg) - MW'(zz_reg);
        m_next[1] = MW'(xy_reg) - MW'(wz_reg);
        m_next[2] = MW'(zx_reg) + MW'(wy_reg);
        m_next[3] = MW'(xy_reg) + MW'(wz_reg);
        m_next[4] = one - MW'(xx_reg) - MW'(zz_reg);
        m_next[5] = MW'(yz_reg) - MW'(wx_reg);
        m_next[6] = MW'(zx_reg) - MW'(wy_reg);
        m_next[7] = MW'(yz_reg) + MW'(wx_reg);
        m_next[8] = one - MW'(xx_reg) - MW'(yy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= m_next;
        end
    end

    assign m = m_reg;

endmodule

// File: hdl/relative_body_motion.sv
// Top level: relative position, velocity, attitude and rate of a target body.
//
// Input stream s_*: one beat carries the observer and target poses (world
// positions, attitude quaternions, body velocities and body rates).
// Output stream m_*: one beat per input beat, in order, with the target's
// position in observer axes, velocity and rate in target axes, the relative
// quaternion, and m_tuser set when any component was clipped to its range.
// Quaternions are used as given, without normalisation.
// From an accepted input beat to its output beat the chain is the matrix
// build, then position, cross product and two matrix rotations of the
// velocity, each of those a two-stage multiply and a rounding adder.
// Throughput is one beat per cycle when not stalled; beats are independent.
// Reset empties the pipeline; s_tready is high straight after reset.
// When m_tready is low with a beat waiting, the whole pipeline holds and
// s_tready falls; nothing is lost or repeated. Bubbles ahead of the output
// keep flowing only while the output register is empty or being taken.
module relative_body_motion
    import rbm_pkg::*;
#(
    parameter  int POS_WIDTH = POS_WIDTH_DEF,
    localparam int IN_W      = ((6*POS_WIDTH + 8*QW + 12*VW + 7) / 8) * 8,
    localparam int OUT_W     = ((3*POS_WIDTH + 4*QW + 6*VW + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // observer_pos_x/y/z, target_pos_x/y/z, observer_attitude, target_attitude,
    // observer_velocity, target_velocity, observer_rate, target_rate, zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // rel_pos_x/y/z, rel_velocity, rel_attitude, rel_rate, zero pad
    output logic [OUT_W-1:0] m_tdata,
    // saturated
    output logic             m_tuser
);

    localparam int PW     = POS_WIDTH;
    localparam int DW     = PW + 1;
    localparam int LAT    = 14;
    localparam int OFS_Q1 = 6*PW;
    localparam int OFS_Q2 = OFS_Q1 + 4*QW;
    localparam int OFS_U1 = OFS_Q2 + 4*QW;
    localparam int OFS_U2 = OFS_U1 + 3*VW;
    localparam int OFS_W1 = OFS_U2 + 3*VW;
    localparam int OFS_W2 = OFS_W1 + 3*VW;

    localparam int PPW = MW + DW;
    localparam int EPW = MW + VW;
    localparam int EIW = EPW + 1;
    localparam int EW  = EIW + $clog2(6) + 1 - E_SH;
    localparam int RPW = MW + EW;
    localparam int CPW = VW + PW;
    localparam int XW  = PW + 30;
    localparam int AW  = XW + $clog2(3) + 1 - CROSS_SH;
    localparam int BPW = MW + AW;
    localparam int BW  = BPW + $clog2(3) + 1 - B_SH;
    localparam int VPW = MW + BW;
    localparam int VIW = VPW + 1;
    localparam int QPW = 2*QW + 1;
    localparam int QIW = QPW + 1;
    localparam int MATW = $bits(mat_t);

    // ---- stream control
    logic           en;
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    assign en         = !valid_reg[LAT-1] || m_tready;
    assign valid_next = {valid_reg[LAT-2:0], s_tvalid};
    assign s_tready   = en;
    assign m_tvalid   = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // ---- input unpack
    logic        [3*DW-1:0] d_in;
    logic signed [QW-1:0]   q2l [4];
    logic signed [QW:0]     cl [4];
    logic signed [QW-1:0]   q1_lane;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_in[i*DW +: DW] = DW'($signed(s_tdata[(3+i)*PW +: PW]))
                             - DW'($signed(s_tdata[i*PW +: PW]));
        end
        q1_lane = '0;
        for (int k = 0; k < 4; k++)
        begin
            q2l[k]  = s_tdata[OFS_Q2 + (3-k)*QW +: QW];
            q1_lane = s_tdata[OFS_Q1 + (3-k)*QW +: QW];
            // conjugate of q1
            cl[k]   = (k == 0) ? (QW+1)'(q1_lane) : -(QW+1)'(q1_lane);
        end
    end

    // ---- payload alignment
    logic [3*DW-1:0] d_s2;
    logic [3*VW-1:0] w1_s2, w2_s2, w1_s5, u1_s7, u2_s13;
    mat_t            r1_s2, r2_s2, r1_s8, r2_s5, r2_s11;

    rbm_delay #(.W(3*DW), .N(2))  u_dly_d  (.clk, .en, .d(d_in), .q(d_s2));
    rbm_delay #(.W(3*VW), .N(2))  u_dly_w1 (.clk, .en, .d(s_tdata[OFS_W1 +: 3*VW]), .q(w1_s2));
    rbm_delay #(.W(3*VW), .N(2))  u_dly_w2 (.clk, .en, .d(s_tdata[OFS_W2 +: 3*VW]), .q(w2_s2));
    rbm_delay #(.W(3*VW), .N(3))  u_dly_wx (.clk, .en, .d(w1_s2), .q(w1_s5));
    rbm_delay #(.W(3*VW), .N(7))  u_dly_u1 (.clk, .en, .d(s_tdata[OFS_U1 +: 3*VW]), .q(u1_s7));
    rbm_delay #(.W(3*VW), .N(13)) u_dly_u2 (.clk, .en, .d(s_tdata[OFS_U2 +: 3*VW]), .q(u2_s13));

    rbm_quat u_quat1 (.clk, .en, .q(s_tdata[OFS_Q1 +: 4*QW]), .m(r1_s2));
    rbm_quat u_quat2 (.clk, .en, .q(s_tdata[OFS_Q2 +: 4*QW]), .m(r2_s2));

    rbm_delay #(.W(MATW), .N(6)) u_dly_r1 (.clk, .en, .d(r1_s2), .q(r1_s8));
    rbm_delay #(.W(MATW), .N(3)) u_dly_r2 (.clk, .en, .d(r2_s2), .q(r2_s5));
    rbm_delay #(.W(MATW), .N(6)) u_dly_r3 (.clk, .en, .d(r2_s5), .q(r2_s11));

    // ---- products and sums
    logic signed [PPW-1:0] pos_prod [3][3];
    logic signed [EPW-1:0] e1_prod [3][3];
    logic signed [EPW-1:0] e2_prod [3][3];
    logic signed [EIW-1:0] e_terms [3][6];
    logic signed [RPW-1:0] rt_prod [3][3];
    logic signed [CPW-1:0] cx_prod [3][2];
    logic signed [XW-1:0]  cx_terms [3][3];
    logic signed [BPW-1:0] b_prod [3][3];
    logic signed [VPW-1:0] v_prod [3][3];
    logic signed [VIW-1:0] v_terms [3][4];
    logic signed [QPW-1:0] q_prod [4][4];
    logic signed [QIW-1:0] q_terms [4][4];

    logic signed [PW-1:0]  pos_s5 [3];
    logic signed [EW-1:0]  e_s5 [3];
    logic signed [VW-1:0]  rt_s8 [3];
    logic signed [AW-1:0]  a_s8 [3];
    logic signed [BW-1:0]  b_s11 [3];
    logic signed [VW-1:0]  vel_s14 [3];
    logic signed [QW-1:0]  qr_s3 [4];
    logic [2:0]            pos_clip, rt_clip, vel_clip;
    logic [3:0]            q_clip;

    genvar i, j;
    generate
        for (i = 0; i < 3; i++)
        begin : g_row
            for (j = 0; j < 3; j++)
            begin : g_col
                rbm_mul #(.AW(MW), .BW(DW)) u_pos (
                    .clk, .en,
                    .a($signed(r1_s2[3*j+i])),
                    .b($signed(d_s2[j*DW +: DW])),
                    .p(pos_prod[i][j])
                );
                rbm_mul #(.AW(MW), .BW(VW)) u_e1 (
                    .clk, .en,
                    .a($signed(r1_s2[3*i+j])),
                    .b(lane3(w1_s2, j)),
                    .p(e1_prod[i][j])
                );
                rbm_mul #(.AW(MW), .BW(VW)) u_e2 (
                    .clk, .en,
                    .a($signed(r2_s2[3*i+j])),
                    .b(lane3(w2_s2, j)),
                    .p(e2_prod[i][j])
                );
                rbm_mul #(.AW(MW), .BW(EW)) u_rt (
                    .clk, .en,
                    .a($signed(r2_s5[3*j+i])),
                    .b(e_s5[j]),
                    .p(rt_prod[i][j])
                );
                rbm_mul #(.AW(MW), .BW(AW)) u_b (
                    .clk, .en,
                    .a($signed(r1_s8[3*i+j])),
                    .b(a_s8[j]),
                    .p(b_prod[i][j])
                );
                rbm_mul #(.AW(MW), .BW(BW)) u_v (
                    .clk, .en,
                    .a($signed(r2_s11[3*j+i])),
                    .b(b_s11[j]),
                    .p(v_prod[i][j])
                );
            end

            // observer rate cross relative position
            rbm_mul #(.AW(VW), .BW(PW)) u_cx0 (
                .clk, .en,
                .a(lane3(w1_s5, (i+1)%3)),
                .b(pos_s5[(i+2)%3]),
                .p(cx_prod[i][0])
            );
            rbm_mul #(.AW(VW), .BW(PW)) u_cx1 (
                .clk, .en,
                .a(lane3(w1_s5, (i+2)%3)),
                .b(pos_s5[(i+1)%3]),
                .p(cx_prod[i][1])
            );

            rbm_sum #(.N(3), .IW(PPW), .SH(POS_SH), .OW(PW)) u_pos_sum (
                .clk, .en, .terms(pos_prod[i]), .res(pos_s5[i]), .clip(pos_clip[i])
            );
            rbm_sum #(.N(6), .IW(EIW), .SH(E_SH), .OW(EW)) u_e_sum (
                .clk, .en, .terms(e_terms[i]), .res(e_s5[i]), .clip()
            );
            rbm_sum #(.N(3), .IW(RPW), .SH(RATE_SH), .OW(VW)) u_rt_sum (
                .clk, .en, .terms(rt_prod[i]), .res(rt_s8[i]), .clip(rt_clip[i])
            );
            rbm_sum #(.N(3), .IW(XW), .SH(CROSS_SH), .OW(AW)) u_cx_sum (
                .clk, .en, .terms(cx_terms[i]), .res(a_s8[i]), .clip()
            );
            rbm_sum #(.N(3), .IW(BPW), .SH(B_SH), .OW(BW)) u_b_sum (
                .clk, .en, .terms(b_prod[i]), .res(b_s11[i]), .clip()
            );
            rbm_sum #(.N(4), .IW(VIW), .SH(VEL_SH), .OW(VW)) u_v_sum (
                .clk, .en, .terms(v_terms[i]), .res(vel_s14[i]), .clip(vel_clip[i])
            );
        end

        for (i = 0; i < 4; i++)
        begin : g_qlane
            for (j = 0; j < 4; j++)
            begin : g_qterm
                rbm_mul #(.AW(QW), .BW(QW+1)) u_q (
                    .clk, .en,
                    .a(q2l[QA[i][j]]),
                    .b(cl[QB[i][j]]),
                    .p(q_prod[i][j])
                );
            end
            rbm_sum #(.N(4), .IW(QIW), .SH(QUAT_SH), .OW(QW)) u_q_sum (
                .clk, .en, .terms(q_terms[i]), .res(qr_s3[i]), .clip(q_clip[i])
            );
        end
    endgenerate

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                e_terms[r][2*c]   = EIW'(e1_prod[r][c]);
                e_terms[r][2*c+1] = -EIW'(e2_prod[r][c]);
                v_terms[r][c]     = -VIW'(v_prod[r][c]);
            end
            cx_terms[r][0] = XW'(cx_prod[r][0]);
            cx_terms[r][1] = -XW'(cx_prod[r][1]);
            // observer velocity joins at the cross product's scale
            cx_terms[r][2] = XW'(lane3(u1_s7, r)) <<< U1_SH;
            v_terms[r][3]  = VIW'(lane3(u2_s13, r)) <<< VEL_SH;
        end
        for (int k = 0; k < 4; k++)
        begin
            for (int t = 0; t < 4; t++)
            begin
                q_terms[k][t] = QN[k][t] ? -QIW'(q_prod[k][t]) : QIW'(q_prod[k][t]);
            end
        end
    end

    // ---- align early results with the velocity
    logic [3*PW:0]   pos_pk_s5, pos_pk_s14;
    logic [4*QW:0]   qr_pk_s3, qr_pk_s14;
    logic [3*VW:0]   rt_pk_s8, rt_pk_s14;
    logic [3*VW-1:0] vel_pk;

    assign pos_pk_s5 = {|pos_clip, pos_s5[2], pos_s5[1], pos_s5[0]};
    assign qr_pk_s3  = {|q_clip, qr_s3[0], qr_s3[1], qr_s3[2], qr_s3[3]};
    assign rt_pk_s8  = {|rt_clip, rt_s8[0], rt_s8[1], rt_s8[2]};
    assign vel_pk    = {vel_s14[0], vel_s14[1], vel_s14[2]};

    rbm_delay #(.W(3*PW+1), .N(9))  u_dly_pos (.clk, .en, .d(pos_pk_s5), .q(pos_pk_s14));
    rbm_delay #(.W(4*QW+1), .N(11)) u_dly_qr  (.clk, .en, .d(qr_pk_s3), .q(qr_pk_s14));
    rbm_delay #(.W(3*VW+1), .N(6))  u_dly_rt  (.clk, .en, .d(rt_pk_s8), .q(rt_pk_s14));

    assign m_tdata = OUT_W'({rt_pk_s14[3*VW-1:0], qr_pk_s14[4*QW-1:0], vel_pk,
                             pos_pk_s14[3*PW-1:0]});
    assign m_tuser = pos_pk_s14[3*PW] | qr_pk_s14[4*QW] | rt_pk_s14[3*VW] | (|vel_clip);

endmodule

// File: hdl/rbm_checker.sv
// Port checker for relative_body_motion, bound to the top level.
module rbm_checker
    import rbm_pkg::*;
#(
    parameter int OUT_W = 288
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser
);

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // the edge that sees reset low has cleared the pipeline by the next one
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input refused with output stage empty");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

endmodule

bind relative_body_motion rbm_checker #(.OUT_W($bits(m_tdata))) u_rbm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
